### rtl/nmea_pkg.sv
package nmea_pkg;

    localparam int MAX_LEN_DEFAULT = 128;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_GGA  = 2'd1;
    localparam logic [1:0] KIND_RMC  = 2'd2;

    localparam logic [3:0] CODE_NONE     = 4'd0;
    localparam logic [3:0] CODE_TIME     = 4'd1;
    localparam logic [3:0] CODE_FIX      = 4'd2;
    localparam logic [3:0] CODE_ALTITUDE = 4'd3;
    localparam logic [3:0] CODE_LAT      = 4'd4;
    localparam logic [3:0] CODE_NS       = 4'd5;
    localparam logic [3:0] CODE_LONG     = 4'd6;
    localparam logic [3:0] CODE_EW       = 4'd7;
    localparam logic [3:0] CODE_SPEED    = 4'd8;
    localparam logic [3:0] CODE_HEADING  = 4'd9;
    localparam logic [3:0] CODE_DATE     = 4'd10;

    localparam logic [7:0] COMMA      = 8'h2C;
    localparam logic [3:0] LAST_FIELD = 4'd8;
    localparam logic [6:0] INDEX_MAX  = 7'd127;
    localparam int         HDR_LEN    = 5;
    localparam int         BODY_START = 6;

    typedef struct packed {
        logic [1:0] sentence_type;
        logic [3:0] field_code;
        logic [7:0] field_char;
        logic [6:0] char_index;
        logic       char_valid;
    } result_t;

    function automatic logic [7:0] hdr_gga_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = "G";
            3'd1:    c = "P";
            3'd2:    c = "G";
            3'd3:    c = "G";
            3'd4:    c = "A";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hdr_rmc_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0:    c = "G";
            3'd1:    c = "P";
            3'd2:    c = "R";
            3'd3:    c = "M";
            3'd4:    c = "C";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] code_for(input logic [1:0] k, input logic [3:0] f);
        logic [3:0] code;
        code = CODE_NONE;
        if (k == KIND_GGA)
        begin
            unique case (f)
                4'd0:    code = CODE_TIME;
                4'd5:    code = CODE_FIX;
                4'd8:    code = CODE_ALTITUDE;
                default: code = CODE_NONE;
            endcase
        end
        else if (k == KIND_RMC)
        begin
            unique case (f)
                4'd2:    code = CODE_LAT;
                4'd3:    code = CODE_NS;
                4'd4:    code = CODE_LONG;
                4'd5:    code = CODE_EW;
                4'd6:    code = CODE_SPEED;
                4'd7:    code = CODE_HEADING;
                4'd8:    code = CODE_DATE;
                default: code = CODE_NONE;
            endcase
        end
        return code;
    endfunction

endpackage

### rtl/nmea_gga_rmc_field_extractor.sv
// takes one nmea character per cycle (no leading dollar sign) and gives exactly one result
// per character, in the cycle after the request is taken; a full rate of one character per
// cycle is sustained unless stalled, set by the single state update per character and the
// one-entry output register, whose ready is the downstream ready whenever a result is held
module nmea_gga_rmc_field_extractor #(
    parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       sentence_start,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] sentence_type,
    output logic [3:0] field_code,
    output logic [7:0] field_char,
    output logic [6:0] char_index,
    output logic       char_valid
);
    import nmea_pkg::*;

    result_t step_result;
    result_t held;
    logic    take;

    assign take = in_valid && in_ready;

    nmea_core #(
        .MAX_LEN(MAX_LEN)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .char_in        (char_in),
        .sentence_start (sentence_start),
        .result         (step_result)
    );

    nmea_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid),
        .load_ready (in_ready),
        .load_data  (step_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (held)
    );

    assign sentence_type = held.sentence_type;
    assign field_code    = held.field_code;
    assign field_char    = held.field_char;
    assign char_index    = held.char_index;
    assign char_valid    = held.char_valid;

endmodule

### rtl/nmea_core.sv
module nmea_core #(
    parameter int MAX_LEN = nmea_pkg::MAX_LEN_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        char_in,
    input  logic              sentence_start,
    output nmea_pkg::result_t result
);
    import nmea_pkg::*;

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LEN);
    localparam logic [PW-1:0] POS_HDR   = PW'(HDR_LEN);
    localparam logic [PW-1:0] POS_LASTH = PW'(HDR_LEN - 1);
    localparam logic [PW-1:0] POS_BODY  = PW'(BODY_START);
    localparam logic [PW-1:0] POS_BODY1 = PW'(BODY_START + 1);

    logic [PW-1:0] position_reg, position_next, pos_cur;
    logic [1:0]    header_match_reg, header_match_next, hm_cur;
    logic [1:0]    kind_reg, kind_next, kind_cur;
    logic [3:0]    field_number_reg, field_number_next, fn_cur;
    logic [6:0]    index_reg, index_next, idx_cur;
    logic          ffe_reg, ffe_next, ffe_cur;
    logic          finished_reg, finished_next, fin_cur;
    logic [3:0]    code;

    always_comb
    begin
        if (sentence_start)
        begin
            pos_cur = '0;
            hm_cur  = 2'b11;
            kind_cur = KIND_NONE;
            fn_cur  = '0;
            idx_cur = '0;
            ffe_cur = 1'b0;
            fin_cur = 1'b0;
        end
        else
        begin
            pos_cur = position_reg;
            hm_cur  = header_match_reg;
            kind_cur = kind_reg;
            fn_cur  = field_number_reg;
            idx_cur = index_reg;
            ffe_cur = ffe_reg;
            fin_cur = finished_reg;
        end

        position_next     = pos_cur;
        header_match_next = hm_cur;
        kind_next         = kind_cur;
        field_number_next = fn_cur;
        index_next        = idx_cur;
        ffe_next          = ffe_cur;
        finished_next     = fin_cur;
        result            = '0;
        code              = CODE_NONE;

        if (!fin_cur)
        begin
            if (pos_cur >= POS_LIMIT)
            begin
                finished_next = 1'b1;
            end
            else
            begin
                position_next = pos_cur + 1'b1;
                if (pos_cur < POS_HDR)
                begin
                    if (char_in != hdr_gga_char(pos_cur[2:0]))
                        header_match_next[0] = 1'b0;
                    if (char_in != hdr_rmc_char(pos_cur[2:0]))
                        header_match_next[1] = 1'b0;
                    if (pos_cur == POS_LASTH)
                    begin
                        priority if (header_match_next[0])
                            kind_next = KIND_GGA;
                        else if (header_match_next[1])
                            kind_next = KIND_RMC;
                        else
                            finished_next = 1'b1;
                    end
                end
                else if (pos_cur >= POS_BODY)
                begin
                    if (pos_cur == POS_BODY && char_in == COMMA)
                        ffe_next = 1'b1;
                    priority if (pos_cur == POS_BODY1 && ffe_cur && char_in == COMMA)
                    begin
                        finished_next = 1'b1;
                    end
                    else if (char_in == COMMA)
                    begin
                        if (fn_cur >= LAST_FIELD)
                            finished_next = 1'b1;
                        else
                            field_number_next = fn_cur + 1'b1;
                        index_next = '0;
                    end
                    else
                    begin
                        code = code_for(kind_cur, fn_cur);
                        if (code != CODE_NONE)
                        begin
                            result.field_code = code;
                            result.field_char = char_in;
                            result.char_index = idx_cur;
                            result.char_valid = 1'b1;
                        end
                        if (idx_cur < INDEX_MAX)
                            index_next = idx_cur + 1'b1;
                    end
                end
            end
        end

        result.sentence_type = kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg     <= '0;
            header_match_reg <= 2'b11;
            kind_reg         <= KIND_NONE;
            field_number_reg <= '0;
            index_reg        <= '0;
            ffe_reg          <= 1'b0;
            finished_reg     <= 1'b1;
        end
        else if (take)
        begin
            position_reg     <= position_next;
            header_match_reg <= header_match_next;
            kind_reg         <= kind_next;
            field_number_reg <= field_number_next;
            index_reg        <= index_next;
            ffe_reg          <= ffe_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

### rtl/nmea_out.sv
module nmea_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  nmea_pkg::result_t load_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nmea_pkg::result_t out_data
);
    import nmea_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load_ready)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
            data_reg <= load_data;
    end

endmodule

### verif/nmea_gga_rmc_field_extractor_test.sv
module nmea_gga_rmc_field_extractor_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nmea_pkg::*;

    localparam int SENTENCE_LIMIT = MAX_LEN_DEFAULT;
    localparam int LIVE_TARGET    = 950;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DRAIN_EVERY    = 12;

    localparam logic [39:0] GGA_TAG = "GPGGA";
    localparam logic [39:0] RMC_TAG = "GPRMC";

    localparam logic [3:0] GGA_CODES [9] = '{CODE_TIME, CODE_NONE, CODE_NONE, CODE_NONE,
                                             CODE_NONE, CODE_FIX, CODE_NONE, CODE_NONE,
                                             CODE_ALTITUDE};
    localparam logic [3:0] RMC_CODES [9] = '{CODE_NONE, CODE_NONE, CODE_LAT, CODE_NS,
                                             CODE_LONG, CODE_EW, CODE_SPEED, CODE_HEADING,
                                             CODE_DATE};

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_FIELD = '0;

    localparam stim_row_t DIRECTED [23] = '{
        // idle after reset
        '{"Z",   1'b0, 1'b1, NO_FIELD},
        '{"G",   1'b1, 1'b0, NO_FIELD},
        '{"P",   1'b0, 1'b0, NO_FIELD},
        '{"G",   1'b0, 1'b0, NO_FIELD},
        '{"G",   1'b0, 1'b0, NO_FIELD},
        '{"A",   1'b0, 1'b0, NO_FIELD},
        '{",",   1'b0, 1'b0, NO_FIELD},
        '{"1",   1'b0, 1'b1, {KIND_GGA, CODE_TIME, 8'h31, 7'd0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, {KIND_GGA, CODE_TIME, 8'hFF, 7'd1, 1'b1}},
        // restart mid-sentence into an unknown header
        '{"X",   1'b1, 1'b0, NO_FIELD},
        '{8'h00, 1'b0, 1'b0, NO_FIELD},
        '{8'h00, 1'b0, 1'b0, NO_FIELD},
        '{8'h00, 1'b0, 1'b0, NO_FIELD},
        '{8'h00, 1'b0, 1'b1, NO_FIELD},
        // empty sentence is rejected
        '{"G",   1'b1, 1'b0, NO_FIELD},
        '{"P",   1'b0, 1'b0, NO_FIELD},
        '{"R",   1'b0, 1'b0, NO_FIELD},
        '{"M",   1'b0, 1'b0, NO_FIELD},
        '{"C",   1'b0, 1'b0, NO_FIELD},
        '{",",   1'b0, 1'b0, NO_FIELD},
        '{",",   1'b0, 1'b0, NO_FIELD},
        '{",",   1'b0, 1'b1, {KIND_RMC, CODE_NONE, 8'h00, 7'd0, 1'b0}},
        '{"5",   1'b0, 1'b1, {KIND_RMC, CODE_NONE, 8'h00, 7'd0, 1'b0}}
    };

    typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] char_in;
    logic       sentence_start;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] sentence_type;
    logic [3:0] field_code;
    logic [7:0] field_char;
    logic [6:0] char_index;
    logic       char_valid;

    // predictor state
    int         sen_pos;
    logic [1:0] hdr_ok;
    logic [1:0] cur_kind;
    logic [3:0] field_no;
    logic [6:0] idx_in_field;
    logic       lead_comma;
    logic       done;

    result_t    expected_fields [$];
    logic [7:0] sentence_chars [$];
    int         live_chars;
    int         bad_fields;
    int         quiet_cycles;
    int         burst_left;
    int         sentence_count;

    rx_mode_t   ready_mode;
    int         ready_hold;
    logic [1:0] ready_phase;

    nmea_gga_rmc_field_extractor #(
        .MAX_LEN(SENTENCE_LIMIT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_in        (char_in),
        .sentence_start (sentence_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sentence_type  (sentence_type),
        .field_code     (field_code),
        .field_char     (field_char),
        .char_index     (char_index),
        .char_valid     (char_valid)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [3:0] wanted_code(input logic [1:0] k, input logic [3:0] f);
        if (f > LAST_FIELD)
            return CODE_NONE;
        if (k == KIND_GGA)
            return GGA_CODES[f];
        if (k == KIND_RMC)
            return RMC_CODES[f];
        return CODE_NONE;
    endfunction

    function automatic result_t extract_field(input logic [7:0] c, input logic s);
        result_t r;
        int      p;
        r = '0;
        if (s)
        begin
            sen_pos      = 0;
            hdr_ok       = 2'b11;
            cur_kind     = KIND_NONE;
            field_no     = '0;
            idx_in_field = '0;
            lead_comma   = 1'b0;
            done         = 1'b0;
        end
        if (!done)
        begin
            p = sen_pos;
            if (p >= SENTENCE_LIMIT)
                done = 1'b1;
            else
            begin
                sen_pos = p + 1;
                if (p < HDR_LEN)
                begin
                    if (c != GGA_TAG[8*(4-p) +: 8])
                        hdr_ok[0] = 1'b0;
                    if (c != RMC_TAG[8*(4-p) +: 8])
                        hdr_ok[1] = 1'b0;
                    if (p == HDR_LEN - 1)
                    begin
                        if (hdr_ok[0])
                            cur_kind = KIND_GGA;
                        else if (hdr_ok[1])
                            cur_kind = KIND_RMC;
                        else
                            done = 1'b1;
                    end
                end
                else if (p >= BODY_START)
                begin
                    if (p == BODY_START && c == COMMA)
                        lead_comma = 1'b1;
                    if (p == BODY_START + 1 && lead_comma && c == COMMA)
                        done = 1'b1;
                    else if (c == COMMA)
                    begin
                        if (field_no >= LAST_FIELD)
                            done = 1'b1;
                        else
                            field_no = field_no + 4'd1;
                        idx_in_field = '0;
                    end
                    else
                    begin
                        r.field_code = wanted_code(cur_kind, field_no);
                        if (r.field_code != CODE_NONE)
                        begin
                            r.field_char = c;
                            r.char_index = idx_in_field;
                            r.char_valid = 1'b1;
                        end
                        if (idx_in_field < INDEX_MAX)
                            idx_in_field = idx_in_field + 7'd1;
                    end
                end
            end
        end
        r.sentence_type = cur_kind;
        return r;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = 8'h30 + 8'($urandom_range(0, 9));
            2:       v = 8'h41 + 8'($urandom_range(0, 25));
            3:       v = ".";
            default: v = 8'($urandom_range(0, 255));
        endcase
        if (v == COMMA)
            v = 8'hAC;
        return v;
    endfunction

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(10, 24);
                default: gap = $urandom_range(1, 5);
            endcase
            hold_off(gap);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    task automatic send_char(input logic [7:0] c, input logic s, input logic typed,
                             input result_t want);
        result_t r;
        pace_sender();
        @(negedge clk);
        in_valid       <= 1'b1;
        char_in        <= c;
        sentence_start <= s;
        do
            @(posedge clk);
        while (!in_ready);
        r = extract_field(c, s);
        live_chars++;
        expected_fields.push_back(typed ? want : r);
    endtask

    task automatic build_sentence();
        int nf;
        int len;
        sentence_chars.delete();
        case ($urandom_range(0, 19))
            18:
            begin
                for (int i = 0; i < 5; i++)
                    sentence_chars.push_back(RMC_TAG[8*(4-i) +: 8]);
                sentence_chars[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            end
            19:
                for (int i = 0; i < 5; i++)
                    sentence_chars.push_back(8'($urandom_range(0, 255)));
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    for (int i = 0; i < 5; i++)
                        sentence_chars.push_back(GGA_TAG[8*(4-i) +: 8]);
                else
                    for (int i = 0; i < 5; i++)
                        sentence_chars.push_back(RMC_TAG[8*(4-i) +: 8]);
            end
        endcase
        sentence_chars.push_back(($urandom_range(0, 7) == 0) ? text_char() : COMMA);
        if ($urandom_range(0, 14) == 0)
        begin
            // empty body
            sentence_chars.push_back(COMMA);
            sentence_chars.push_back(COMMA);
            for (int i = $urandom_range(0, 3); i > 0; i--)
                sentence_chars.push_back(text_char());
        end
        else
        begin
            nf = $urandom_range(1, 11);
            for (int f = 0; f < nf; f++)
            begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 135)
                                                   : $urandom_range(0, 7);
                for (int i = 0; i < len; i++)
                    sentence_chars.push_back(text_char());
                if (f < nf - 1 || $urandom_range(0, 5) != 0)
                    sentence_chars.push_back(COMMA);
            end
        end
        // cut short so that the next start lands mid-sentence
        if ($urandom_range(0, 9) == 0)
            sentence_chars = sentence_chars[0:$urandom_range(0, sentence_chars.size() - 1)];
    endtask

    always @(negedge clk)
    begin
        ready_phase <= ready_phase + 2'd1;
        if (ready_hold == 0)
        begin
            ready_mode <= rx_mode_t'($urandom_range(0, 3));
            ready_hold <= $urandom_range(40, 300);
        end
        else
            ready_hold <= ready_hold - 1;
        case (ready_mode)
            RX_FREE:     out_ready <= 1'b1;
            RX_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: out_ready <= (ready_phase == 2'd0);
            default:     out_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t exp_field;
        if (rst_n && out_valid && out_ready)
        begin
            got = {sentence_type, field_code, field_char, char_index, char_valid};
            if (expected_fields.size() == 0)
            begin
                bad_fields++;
                if (bad_fields <= REPORT_LIMIT)
                    $display("unexpected result: type %0d code %0d char %02h index %0d valid %0d",
                             got.sentence_type, got.field_code, got.field_char,
                             got.char_index, got.char_valid);
            end
            else
            begin
                exp_field = expected_fields.pop_front();
                if (got.sentence_type != exp_field.sentence_type
                    || got.field_code != exp_field.field_code
                    || got.field_char != exp_field.field_char
                    || got.char_index != exp_field.char_index
                    || got.char_valid != exp_field.char_valid)
                begin
                    bad_fields++;
                    if (bad_fields <= REPORT_LIMIT)
                        $display({"mismatch: expected type %0d code %0d char %02h index %0d ",
                                  "valid %0d, got type %0d code %0d char %02h index %0d ",
                                  "valid %0d"},
                                 exp_field.sentence_type, exp_field.field_code,
                                 exp_field.field_char, exp_field.char_index,
                                 exp_field.char_valid, got.sentence_type, got.field_code,
                                 got.field_char, got.char_index, got.char_valid);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        char_in        = 8'h00;
        sentence_start = 1'b0;
        out_ready      = 1'b0;
        ready_mode     = RX_FREE;
        ready_hold     = 0;
        ready_phase    = 2'd0;
        quiet_cycles   = 0;
        bad_fields     = 0;
        live_chars     = 0;
        burst_left     = 0;
        sentence_count = 0;
        sen_pos        = 0;
        hdr_ok         = 2'b11;
        cur_kind       = KIND_NONE;
        field_no       = '0;
        idx_in_field   = '0;
        lead_comma     = 1'b0;
        done           = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
            send_char(DIRECTED[i].ch, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].want);

        while (live_chars < LIVE_TARGET)
        begin
            build_sentence();
            // stray characters between sentences
            if ($urandom_range(0, 7) == 0)
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_FIELD);
            foreach (sentence_chars[i])
                send_char(sentence_chars[i], i == 0, 1'b0, NO_FIELD);
            sentence_count++;
            if (sentence_count % DRAIN_EVERY == 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                wait (expected_fields.size() == 0);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (expected_fields.size() == 0);
        repeat (8) @(posedge clk);
        if (bad_fields == 0 && expected_fields.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
